@@ rtl/heightmap_brush_edit_unit_macros.svh @@
// assertion macros for the heightmap brush edit unit
// expects clk_i and rst_ni in the scope of use
`ifndef HEIGHTMAP_BRUSH_EDIT_UNIT_MACROS_SVH
`define HEIGHTMAP_BRUSH_EDIT_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define HBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define HBE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/hbe_pkg.sv @@
// shared types, codes and constants of the heightmap brush edit unit
// no dependencies
`timescale 1ns / 1ps

package hbe_pkg;

  localparam int MAP_SIZE_DEF    = 128;
  localparam int KERNEL_SIZE_DEF = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int COORD_W    = 12;

  // ratio division: (num << 32) / den, num and den up to 17 bits
  localparam int QDIV_W = 49;
  localparam int DEN_W  = 17;
  localparam int QUOT_W = 33;
  localparam int ROOT_W = 17;

  localparam logic [ROOT_W-1:0] FACTOR_ONE = 17'h10000;
  localparam logic [12:0]       RECIP_100  = 13'd5243;
  localparam int                RECIP_SH   = 19;
  localparam logic [6:0]        PRESS_MAX  = 7'd100;

  typedef enum logic [1:0] {
    CFG_BRUSH_MODE = 2'd0,
    CFG_PRESSURE   = 2'd1,
    CFG_MAP_ROWS   = 2'd2,
    CFG_MAP_COLS   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_ELEVATE = 2'd0,
    MODE_LOWER   = 2'd1,
    MODE_SMOOTH  = 2'd2
  } brush_mode_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EDIT  = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SQUARE,
    S_QGO,
    S_QWAIT,
    S_RGO,
    S_RWAIT,
    S_WIN,
    S_WLAST,
    S_AGO,
    S_AWAIT,
    S_BLEND,
    S_MULT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               action;
    logic        [6:0]  row;
    logic        [6:0]  col;
    logic signed [15:0] sample_value;
    logic        [6:0]  chunk_row;
    logic        [6:0]  chunk_col;
    logic        [7:0]  chunk_rows;
    logic        [7:0]  chunk_cols;
  } in_t;

  typedef struct packed {
    logic signed [15:0] new_height;
    logic        [6:0]  out_row;
    logic        [6:0]  out_col;
  } out_t;

endpackage

@@ rtl/hbe_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// dividend is top aligned, steps gives the number of quotient bits
`timescale 1ns / 1ps

module hbe_div import hbe_pkg::*; #(
  parameter int DW = QDIV_W,
  parameter int VW = DEN_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DW-1:0]          dividend_i,
  input  logic [VW-1:0]          divisor_i,
  input  logic [$clog2(DW+1)-1:0] steps_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [DW-1:0]          quot_o,
  output logic [VW-1:0]          rem_o
);

  localparam int CNT_W = $clog2(DW+1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    acc_q, acc_d;
  logic [VW-1:0]    rem_q, rem_d, div_q;
  logic [VW:0]      trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, acc_q[DW-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
    rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
    acc_d = {acc_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/hbe_sqrt.sv @@
// digit-by-digit integer square root, one result bit per cycle
// depends on hbe_pkg for widths
`timescale 1ns / 1ps

module hbe_sqrt import hbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QUOT_W-1:0] value_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int RW = QUOT_W + 1;

  logic          busy_q, done_q;
  logic [RW-1:0] v_q, res_q, bit_q, t;
  logic          ge;

  always_comb begin
    t  = res_q + bit_q;
    ge = v_q >= t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= {1'b0, value_i};
      res_q <= '0;
      bit_q <= RW'(1) << (QUOT_W - 1);
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= v_q - t;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

@@ rtl/heightmap_brush_edit_unit.sv @@
// Heightmap brush edit unit: a write transfer stores one signed 16-bit sample in the
// single-port height memory. An edit transfer returns the brushed height of its
// target cell, or nothing when the target lies outside the chunk or the map; it is
// not written back. One item is in work at a time. An edit runs a 49-step serial
// divider that forms the squared distance ratio and a 17-step root after it, and
// smoothing adds one memory read per window cell inside the map and a second serial
// division for the average. The memory needs no clearing after reset.
`timescale 1ns / 1ps

module heightmap_brush_edit_unit import hbe_pkg::*; #(
  parameter int MAP_SIZE    = MAP_SIZE_DEF,
  parameter int KERNEL_SIZE = KERNEL_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "heightmap_brush_edit_unit_macros.svh"

  localparam int IW    = $clog2(MAP_SIZE);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int KW    = $clog2(KERNEL_SIZE);
  localparam int HALF  = KERNEL_SIZE / 2;
  localparam int KK    = KERNEL_SIZE * KERNEL_SIZE;
  localparam int NW    = $clog2(KK + 1);
  localparam int SW    = 16 + $clog2(KK);
  localparam int DSW   = $clog2(QDIV_W + 1);

  localparam logic [KW-1:0]      KLAST = KW'(KERNEL_SIZE - 1);
  localparam logic [COORD_W-1:0] MAPC  = COORD_W'(MAP_SIZE);

  state_e state_q, state_d;

  logic [1:0] brush_mode_q;
  logic [6:0] pressure_q;
  logic [7:0] map_rows_q, map_cols_q;

  in_t                item_q;
  logic [15:0]        cur_q;
  logic [9:0]         dr_q, dc_q;
  logic [15:0]        drsq_q, dcsq_q, crsq_q, ccsq_q;
  logic [10:0]        scale_q;
  logic [ROOT_W-1:0]  factor_q;
  logic [KW-1:0]      wi_q, wj_q;
  logic               pend_q;
  logic [SW-1:0]      sum_q;
  logic [NW-1:0]      cnt_q;
  logic               neg_q;
  logic [17:0]        avg_q;
  logic [27:0]        mprod_q;
  logic signed [35:0] sprod_q;

  logic               out_valid_q;
  out_t               out_q;

  logic [15:0]        mem [DEPTH];
  logic [15:0]        rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      waddr, raddr;

  logic               div_start, div_busy, div_done;
  logic [QDIV_W-1:0]  div_dividend, div_quot;
  logic [DEN_W-1:0]   div_divisor, div_rem;
  logic [DSW-1:0]     div_steps;
  logic               root_start, root_done;
  logic [ROOT_W-1:0]  root;

  logic               in_acc, out_free, out_load;
  logic [COORD_W-1:0] mr, mc, trow, tcol, wr, wc;
  logic               target_ok, win_inb, win_last;
  logic [8:0]         chunk_rend, chunk_cend;
  logic [9:0]         dr_d, dc_d;
  logic signed [19:0] drsq_full, dcsq_full;
  logic [6:0]         p_sat;
  logic [SW-1:0]      sum_mag, avg_full;
  logic signed [17:0] dval;
  logic [23:0]        dprod;
  logic [15:0]        delta;
  logic [15:0]        result;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign out_free   = !out_valid_q || !out_stall_i;

  // geometry
  always_comb begin
    mr   = ({4'b0, map_rows_q} > MAPC) ? MAPC : {4'b0, map_rows_q};
    mc   = ({4'b0, map_cols_q} > MAPC) ? MAPC : {4'b0, map_cols_q};
    trow = COORD_W'(item_q.row);
    tcol = COORD_W'(item_q.col);
    chunk_rend = 9'(item_q.chunk_row) + 9'(item_q.chunk_rows);
    chunk_cend = 9'(item_q.chunk_col) + 9'(item_q.chunk_cols);
    target_ok  = (item_q.row >= item_q.chunk_row) && (9'(item_q.row) < chunk_rend) &&
                 (item_q.col >= item_q.chunk_col) && (9'(item_q.col) < chunk_cend) &&
                 (trow < mr) && (tcol < mc);
    dr_d = 10'({item_q.row, 1'b0}) - 10'({item_q.chunk_row, 1'b0}) - 10'(item_q.chunk_rows);
    dc_d = 10'({item_q.col, 1'b0}) - 10'({item_q.chunk_col, 1'b0}) - 10'(item_q.chunk_cols);
    drsq_full = $signed(dr_q) * $signed(dr_q);
    dcsq_full = $signed(dc_q) * $signed(dc_q);
    p_sat = (pressure_q > PRESS_MAX) ? PRESS_MAX : pressure_q;
    wr = trow - COORD_W'(HALF) + COORD_W'(wi_q);
    wc = tcol - COORD_W'(HALF) + COORD_W'(wj_q);
    win_inb  = !wr[COORD_W-1] && !wc[COORD_W-1] && (wr < mr) && (wc < mc);
    win_last = (wi_q == KLAST) && (wj_q == KLAST);
    sum_mag  = sum_q[SW-1] ? (~sum_q + SW'(1)) : sum_q;
    avg_full = neg_q ? ((div_rem != '0) ? ~div_quot[SW-1:0] : (~div_quot[SW-1:0] + SW'(1)))
                     : div_quot[SW-1:0];
    dval  = $signed(avg_q) - $signed({{2{cur_q[15]}}, cur_q});
    dprod = 24'(mprod_q[26:16]) * 24'(RECIP_100);
    delta = 16'(dprod[23:RECIP_SH]);
  end

  always_comb begin
    case (brush_mode_q)
      MODE_ELEVATE: result = cur_q + delta;
      MODE_LOWER:   result = cur_q - delta;
      MODE_SMOOTH:  result = (cnt_q == '0) ? cur_q : cur_q + sprod_q[31:16];
      default:      result = cur_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc && in_data_i.action == ACT_EDIT) state_d = S_CHECK;
      S_CHECK:  state_d = target_ok ? S_SQUARE : S_IDLE;
      S_SQUARE: state_d = S_QGO;
      S_QGO:    state_d = S_QWAIT;
      S_QWAIT:  if (div_done) state_d = S_RGO;
      S_RGO:    state_d = S_RWAIT;
      S_RWAIT: begin
        if (root_done) begin
          case (brush_mode_q)
            MODE_ELEVATE, MODE_LOWER: state_d = S_MULT;
            MODE_SMOOTH:              state_d = S_WIN;
            default:                  state_d = S_DONE;
          endcase
        end
      end
      S_WIN:    if (win_last) state_d = S_WLAST;
      S_WLAST:  state_d = S_AGO;
      S_AGO:    state_d = S_AWAIT;
      S_AWAIT:  if (div_done) state_d = S_BLEND;
      S_BLEND:  state_d = S_DONE;
      S_MULT:   state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    waddr        = {in_data_i.row[IW-1:0], in_data_i.col[IW-1:0]};
    raddr        = {trow[IW-1:0], tcol[IW-1:0]};
    div_start    = 1'b0;
    div_dividend = {DEN_W'(drsq_q) + DEN_W'(dcsq_q), (QDIV_W-DEN_W)'(0)};
    div_divisor  = DEN_W'(crsq_q) + DEN_W'(ccsq_q);
    div_steps    = DSW'(QDIV_W);
    root_start   = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        mem_we = in_acc && in_data_i.action == ACT_WRITE &&
                 (COORD_W'(in_data_i.row) < MAPC) && (COORD_W'(in_data_i.col) < MAPC);
      end
      S_CHECK: mem_re = target_ok;
      S_QGO:   div_start = 1'b1;
      S_RGO:   root_start = 1'b1;
      S_WIN: begin
        mem_re = win_inb;
        raddr  = {wr[IW-1:0], wc[IW-1:0]};
      end
      S_AGO: begin
        div_start    = 1'b1;
        div_dividend = {sum_mag, (QDIV_W-SW)'(0)};
        div_divisor  = DEN_W'(cnt_q);
        div_steps    = DSW'(SW);
      end
      S_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      brush_mode_q <= MODE_ELEVATE;
      pressure_q   <= 7'd50;
      map_rows_q   <= 8'd128;
      map_cols_q   <= 8'd128;
      wi_q         <= '0;
      wj_q         <= '0;
      pend_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BRUSH_MODE: brush_mode_q <= cfg_data_i[1:0];
          CFG_PRESSURE:   pressure_q   <= cfg_data_i[6:0];
          CFG_MAP_ROWS:   map_rows_q   <= cfg_data_i;
          CFG_MAP_COLS:   map_cols_q   <= cfg_data_i;
          default: ;
        endcase
      end
      pend_q <= (state_q == S_WIN) && win_inb;
      if (state_q == S_WIN) begin
        wj_q <= wj_q + KW'(1);
        if (wj_q == KLAST) begin
          wj_q <= '0;
          wi_q <= wi_q + KW'(1);
        end
      end else begin
        wi_q <= '0;
        wj_q <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    case (state_q)
      S_CHECK: begin
        dr_q <= dr_d;
        dc_q <= dc_d;
      end
      S_SQUARE: begin
        cur_q   <= rdata_q;
        drsq_q  <= drsq_full[15:0];
        dcsq_q  <= dcsq_full[15:0];
        crsq_q  <= 16'(item_q.chunk_rows) * 16'(item_q.chunk_rows);
        ccsq_q  <= 16'(item_q.chunk_cols) * 16'(item_q.chunk_cols);
        scale_q <= 11'd100 + 11'(p_sat) * 11'd19;
        sum_q   <= '0;
        cnt_q   <= '0;
      end
      S_RWAIT: begin
        if (root_done) factor_q <= (root >= FACTOR_ONE) ? '0 : FACTOR_ONE - root;
      end
      S_AGO:   neg_q <= sum_q[SW-1];
      S_AWAIT: if (div_done) avg_q <= avg_full[17:0];
      S_BLEND: sprod_q <= dval * $signed({1'b0, factor_q});
      S_MULT:  mprod_q <= 28'(factor_q) * 28'(scale_q);
      default: ;
    endcase
    if (pend_q) begin
      sum_q <= sum_q + {{(SW-16){rdata_q[15]}}, rdata_q};
      cnt_q <= cnt_q + NW'(1);
    end
    if (out_load) begin
      out_q.new_height <= result;
      out_q.out_row    <= item_q.row;
      out_q.out_col    <= item_q.col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= in_data_i.sample_value;
    if (mem_re) rdata_q <= mem[raddr];
  end

  hbe_div #(
    .DW(QDIV_W),
    .VW(DEN_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .steps_i   (div_steps),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  hbe_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_start),
    .value_i(div_quot[QUOT_W-1:0]),
    .done_o (root_done),
    .root_o (root)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HBE_ASSERT(a_div_free, div_start |-> !div_busy, "divider restarted while busy")
  `HBE_ASSERT(a_factor_range, (state_q == S_MULT) |-> (factor_q <= FACTOR_ONE), "factor high")
  `HBE_ASSERT(a_mem_port, mem_we |-> !mem_re, "memory read and write in one cycle")
  `HBE_ASSERT_NEXT(a_done_hold, state_q == S_DONE && !out_free, state_q == S_DONE, "lost")

endmodule
